// File: sv/flash_erase_program_tracker_top_defines.svh
// Assertion macros for the flash erase and program tracker.
`ifndef FLASH_ERASE_PROGRAM_TRACKER_TOP_DEFINES_SVH
`define FLASH_ERASE_PROGRAM_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define FEPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FEPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/fept_pkg.sv
// Types, constants and helper functions shared by the tracker modules.
`default_nettype none

package fept_pkg;

   localparam int TableEntries = 128;
   localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

   localparam logic [1:0] ActWrite = 2'd0;
   localparam logic [1:0] ActFlush = 2'd1;
   localparam logic [1:0] ActClear = 2'd2;

   localparam logic [15:0] FullMask = 16'hffff;
   localparam logic [31:0] NoAddress = 32'hffffffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [23:0] address;
      logic [12:0] length;
      logic        erase_ok;
      logic        program_ok;
   } req_type;

   typedef struct packed {
      logic        erase_issued;
      logic        write_accepted;
      logic        overlap_seen;
      logic [31:0] first_address;
      logic [31:0] bytes_written;
      logic [11:0] min_page;
      logic        min_page_valid;
   } rsp_type;

   typedef struct packed {
      logic [11:0] page;
      logic        erased;
      logic [15:0] mask;
   } entry_type;

   typedef struct packed {
      logic            en;
      logic [IdxW-1:0] addr;
      entry_type       data;
   } entry_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   // Blocks of the page touched by a write: ceil(len/256) steps from the start block.
   function automatic logic [15:0] block_mask(input logic [23:0] addr, input logic [12:0] len);
      logic [13:0] sum;
      logic [5:0]  steps;
      logic [4:0]  blk;
      logic [4:0]  diff;
      logic [15:0] m;
      sum   = {1'b0, len} + 14'd255;
      steps = sum[13:8];
      blk   = {1'b0, addr[11:8]};
      m     = '0;
      for (int b = 0; b < 16; b++) begin
         diff = 5'(b) - blk;
         m[b] = (5'(b) >= blk) && ({1'b0, diff} < steps);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// File: sv/fept_table.sv
// Page table storage: entry memory with registered read, valid bits in flops.
`default_nettype none

module fept_table (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      rd_en,
   input  wire logic [fept_pkg::IdxW-1:0] rd_addr,
   output logic                           rd_valid,
   output fept_pkg::entry_type            rd_data,
   input  wire fept_pkg::entry_wr_type    wr,
   input  wire logic                      clear_all
);

   fept_pkg::entry_type mem [fept_pkg::TableEntries];
   logic [fept_pkg::TableEntries-1:0] valid_ff;
   logic                              rd_valid_ff;
   fept_pkg::entry_type               rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/fept_ctrl.sv
// Sequencer: table scan, read-modify-write of one entry, session registers.
`default_nettype none

module fept_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire fept_pkg::req_type         req_data,
   output logic                           res_valid,
   output fept_pkg::rsp_type              res_data,
   input  wire logic                      res_free,
   output logic                           rd_en,
   output logic [fept_pkg::IdxW-1:0]      rd_addr,
   input  wire logic                      rd_valid,
   input  wire fept_pkg::entry_type       rd_data,
   output fept_pkg::entry_wr_type         wr,
   output logic                           clear_all
);

   fept_pkg::state_type state_ff, state_in;
   fept_pkg::req_type   req_ff;
   logic [fept_pkg::IdxW-1:0] cnt_ff, cnt_in;
   logic                      cmp_ff;
   logic [fept_pkg::IdxW-1:0] cmp_idx_ff;
   logic                      hit_ff, hit_in;
   logic [fept_pkg::IdxW-1:0] hit_idx_ff, hit_idx_in;
   fept_pkg::entry_type       hit_ent_ff, hit_ent_in;
   logic                      free_ff, free_in;
   logic [fept_pkg::IdxW-1:0] free_idx_ff, free_idx_in;
   logic [31:0]               lowest_ff, lowest_in;
   logic [31:0]               count_ff, count_in;
   logic [11:0]               fpage_ff, fpage_in;
   logic                      fvalid_ff, fvalid_in;

   logic        accept, commit, in_update;
   logic [11:0] page;
   logic [15:0] m, base_mask, merged;
   logic        is_write, is_clear, need_erase, fail, proceed, have_idx, new_rec;
   logic [31:0] addr_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fept_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.action == fept_pkg::ActWrite) ? fept_pkg::ST_SCAN
                                                                  : fept_pkg::ST_UPDATE;
            end
         end
         fept_pkg::ST_SCAN: begin
            if (cnt_ff == fept_pkg::LastIdx) begin
               state_in = fept_pkg::ST_DRAIN;
            end
         end
         fept_pkg::ST_DRAIN: begin
            state_in = fept_pkg::ST_UPDATE;
         end
         fept_pkg::ST_UPDATE: begin
            if (res_free) begin
               state_in = fept_pkg::ST_IDLE;
            end
         end
         default: state_in = fept_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      in_update = 1'b0;
      unique case (state_ff)
         fept_pkg::ST_IDLE:   req_stall = 1'b0;
         fept_pkg::ST_SCAN:   rd_en     = 1'b1;
         fept_pkg::ST_DRAIN:  req_stall = 1'b1;
         fept_pkg::ST_UPDATE: in_update = 1'b1;
         default:             req_stall = 1'b1;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign res_valid = in_update;
   assign commit    = in_update && res_free;
   assign rd_addr   = cnt_ff;
   assign cnt_in    = accept ? '0 : (rd_en ? cnt_ff + 1'b1 : cnt_ff);

   // scan compare, one entry per cycle as read data returns
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_ent_in  = hit_ent_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (accept) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (cmp_ff) begin
         if (rd_valid && rd_data.page == req_ff.address[23:12] && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_ent_in = rd_data;
         end
         if (!rd_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   // update of the entry and the session
   always_comb begin
      page       = req_ff.address[23:12];
      m          = fept_pkg::block_mask(req_ff.address, req_ff.length);
      is_write   = req_ff.action == fept_pkg::ActWrite;
      is_clear   = req_ff.action == fept_pkg::ActClear;
      need_erase = !hit_ff || !hit_ent_ff.erased;
      fail       = need_erase && !req_ff.erase_ok;
      proceed    = is_write && !fail;
      have_idx   = hit_ff || free_ff;
      new_rec    = proceed && !hit_ff && free_ff;
      base_mask  = need_erase ? 16'h0000 : hit_ent_ff.mask;
      merged     = base_mask | m;
      addr_ext   = {8'h00, req_ff.address};

      wr.en          = commit && proceed && have_idx && (need_erase || req_ff.program_ok);
      wr.addr        = hit_ff ? hit_idx_ff : free_idx_ff;
      wr.data.page   = page;
      wr.data.mask   = req_ff.program_ok ? merged : base_mask;
      wr.data.erased = req_ff.program_ok ? (merged != fept_pkg::FullMask) : 1'b1;

      clear_all = commit && (req_ff.action == fept_pkg::ActFlush || is_clear);

      lowest_in = lowest_ff;
      count_in  = count_ff;
      fpage_in  = fpage_ff;
      fvalid_in = fvalid_ff;
      if (is_clear) begin
         lowest_in = fept_pkg::NoAddress;
         count_in  = '0;
      end else if (proceed) begin
         if (addr_ext < lowest_ff) begin
            lowest_in = addr_ext;
         end
         if (req_ff.program_ok) begin
            count_in = count_ff + {19'h00000, req_ff.length};
         end
      end
      if (req_ff.action == fept_pkg::ActFlush || is_clear) begin
         fpage_in  = '0;
         fvalid_in = 1'b0;
      end else if (new_rec && (!fvalid_ff || page < fpage_ff)) begin
         fpage_in  = page;
         fvalid_in = 1'b1;
      end

      res_data.erase_issued   = is_write && need_erase;
      res_data.write_accepted = !(is_write && fail);
      res_data.overlap_seen   = proceed && have_idx && (|(base_mask & m));
      res_data.first_address  = lowest_in;
      res_data.bytes_written  = count_in;
      res_data.min_page       = fpage_in;
      res_data.min_page_valid = fvalid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fept_pkg::ST_IDLE;
         cmp_ff    <= 1'b0;
         lowest_ff <= fept_pkg::NoAddress;
         count_ff  <= '0;
         fpage_ff  <= '0;
         fvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_ff   <= rd_en;
         if (commit) begin
            lowest_ff <= lowest_in;
            count_ff  <= count_in;
            fpage_ff  <= fpage_in;
            fvalid_ff <= fvalid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cnt_ff;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

endmodule

`default_nettype wire

// File: sv/flash_erase_program_tracker_top.sv
// Top level of the flash erase and program tracker: table, sequencer, result register.
//
//   channel   direction  word type            handshake
//   req_      in         fept_pkg::req_type   req_valid / req_stall
//   rsp_      out        fept_pkg::rsp_type   rsp_valid / rsp_stall
//
// A write word scans the whole table before the next acceptance: the scan
// reads one table entry per cycle through the single read port of the entry
// memory, then a drain step takes the last read and an update step writes the
// entry back. Flush, clear and unused action words skip the scan and go to the
// update step. Reset clears the valid flops at once, so no clearing pass is
// needed. A stalled result holds in the output register; the sequencer waits
// in its update step only while that register is still full.
`default_nettype none

`include "flash_erase_program_tracker_top_defines.svh"

module flash_erase_program_tracker_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire fept_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fept_pkg::rsp_type      rsp_data
);

   logic                      rd_en;
   logic [fept_pkg::IdxW-1:0] rd_addr;
   logic                      rd_valid;
   fept_pkg::entry_type       rd_data;
   fept_pkg::entry_wr_type    wr;
   logic                      clear_all;

   logic              res_valid;
   logic              res_free;
   fept_pkg::rsp_type res_data;

   logic              rsp_valid_ff, rsp_valid_in;
   fept_pkg::rsp_type rsp_data_ff;

   // entry memory and valid flops
   fept_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_valid  (rd_valid),
      .rd_data   (rd_data),
      .wr        (wr),
      .clear_all (clear_all)
   );

   // scan, read-modify-write and session bookkeeping
   fept_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_free  (res_free),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_valid  (rd_valid),
      .rd_data   (rd_data),
      .wr        (wr),
      .clear_all (clear_all)
   );

   // The output register is free when empty or when its word leaves this cycle.
   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (res_valid && res_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the finished word; hold it while stalled
   always_ff @(posedge clock) begin
      if (res_valid && res_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted word always makes the block busy in the next cycle
   `FEPT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "word accepted but block not busy")
   // a finished word that cannot leave is held by the sequencer
   `FEPT_ASSERT_NEXT(a_result_held, clock, reset, res_valid && !res_free, res_valid, "pending result dropped")
   // a refused write never reports overlap and always issued an erase
   `FEPT_ASSERT_NOW(a_refused_write, clock, reset, rsp_valid && !rsp_data.write_accepted, rsp_data.erase_issued && !rsp_data.overlap_seen, "inconsistent refused write")
   // table writes and table clears come only from the update step
   `FEPT_ASSERT_NOW(a_write_in_update, clock, reset, wr.en || clear_all, res_valid && res_free, "table changed outside update")

endmodule

`default_nettype wire
